@@ rtl/rcsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsfd_pkg
// Shared types and constants of the servo frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsfd_pkg;

    localparam int NumChannels   = 14;
    localparam int ChIdxW        = (NumChannels > 1) ? $clog2(NumChannels) : 1;
    localparam int FrameDepth    = 32;
    localparam int FramePtrW     = 5;
    localparam int QueueDepth    = 2;
    localparam int QueuePtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QueueCountW   = $clog2(QueueDepth + 1);
    localparam int ApbAddrW      = 3;

    localparam logic [7:0]  FrameMax      = 8'h20;
    localparam logic [7:0]  FrameOverhead = 8'd3;
    localparam logic [7:0]  CmdChannels   = 8'h40;
    localparam logic [15:0] ChkInit       = 16'hFFFF;
    localparam logic [7:0]  GapMsReset    = 8'd3;

    // register index, taken from paddr[2]
    localparam logic RegGapMs = 1'b0;

    typedef enum logic [2:0] {
        PS_LENGTH  = 3'd0,
        PS_DATA    = 3'd1,
        PS_CHK_LO  = 3'd2,
        PS_CHK_HI  = 3'd3,
        PS_DISCARD = 3'd4
    } parse_state_t;

    // classified item passed from front to back
    typedef struct packed {
        logic       is_read;
        logic       resync;
        logic [7:0] data;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/rcsfd_req_if.sv @@
// ----------------------------------------------------------------------------
// rcsfd_req_if
// Input channel: received bytes and channel read requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsfd_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;
    logic [7:0]  channel_index;

    modport source (output valid, func, rx_byte, now_ms, channel_index, input ready);
    modport sink (input valid, func, rx_byte, now_ms, channel_index, output ready);
endinterface

`default_nettype wire

@@ rtl/rcsfd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rcsfd_rsp_if
// Output channel: read values and frame accept flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcsfd_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic        frame_accepted;

    modport source (output valid, read_value, frame_accepted, input ready);
    modport sink (input valid, read_value, frame_accepted, output ready);
endinterface

`default_nettype wire

@@ rtl/rcsfd_front.sv @@
// ----------------------------------------------------------------------------
// rcsfd_front
// Accepts items, checks the inter-byte gap and pushes classified items.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       gap_ms,
    rcsfd_req_if.sink             req,
    input  wire logic             q_full,
    output logic                  push,
    output rcsfd_pkg::item_t      push_item
);

    logic [31:0] last_time_reg;
    logic [31:0] last_time_next;
    logic [31:0] elapsed;

    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

    // wrapping difference against the previous byte
    assign elapsed = req.now_ms - last_time_reg;

    always_comb
    begin
        push_item.is_read = req.func;
        push_item.resync  = (elapsed >= {24'h000000, gap_ms});
        push_item.data    = req.func ? req.channel_index : req.rx_byte;
    end

    always_comb
    begin
        last_time_next = last_time_reg;
        if (push && !req.func)
        begin
            last_time_next = req.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
        end
        else
        begin
            last_time_reg <= last_time_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rcsfd_queue.sv @@
// ----------------------------------------------------------------------------
// rcsfd_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rcsfd_pkg::item_t push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  q_valid,
    output rcsfd_pkg::item_t      q_item
);

    localparam logic [rcsfd_pkg::QueuePtrW-1:0] LastPtr =
        rcsfd_pkg::QueuePtrW'(rcsfd_pkg::QueueDepth - 1);
    localparam logic [rcsfd_pkg::QueueCountW-1:0] FullCount =
        rcsfd_pkg::QueueCountW'(rcsfd_pkg::QueueDepth);

    rcsfd_pkg::item_t                      entry_reg [rcsfd_pkg::QueueDepth];
    logic [rcsfd_pkg::QueuePtrW-1:0]       wr_ptr_reg;
    logic [rcsfd_pkg::QueuePtrW-1:0]       wr_ptr_next;
    logic [rcsfd_pkg::QueuePtrW-1:0]       rd_ptr_reg;
    logic [rcsfd_pkg::QueuePtrW-1:0]       rd_ptr_next;
    logic [rcsfd_pkg::QueueCountW-1:0]     count_reg;
    logic [rcsfd_pkg::QueueCountW-1:0]     count_next;

    assign full    = (count_reg == FullCount);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("item pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("item popped from empty queue");

endmodule

`default_nettype wire

@@ rtl/rcsfd_back.sv @@
// ----------------------------------------------------------------------------
// rcsfd_back
// Frame parser, checksum, channel store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsfd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire rcsfd_pkg::item_t q_item,
    output logic                  pop,
    rcsfd_rsp_if.source           rsp
);

    rcsfd_pkg::parse_state_t            state_reg;
    rcsfd_pkg::parse_state_t            state_next;
    rcsfd_pkg::parse_state_t            cur_state;
    logic [rcsfd_pkg::FramePtrW-1:0]    ptr_reg;
    logic [rcsfd_pkg::FramePtrW-1:0]    ptr_next;
    logic [rcsfd_pkg::FramePtrW-1:0]    ptr_inc;
    logic [rcsfd_pkg::FramePtrW-1:0]    len_reg;
    logic [rcsfd_pkg::FramePtrW-1:0]    len_next;
    logic [15:0]                        csum_reg;
    logic [15:0]                        csum_next;
    logic [7:0]                         chk_lo_reg;
    logic [7:0]                         chk_lo_next;
    logic [7:0]                         frame_reg [rcsfd_pkg::FrameDepth];
    logic [15:0]                        chan_reg [rcsfd_pkg::NumChannels];

    logic        byte_item;
    logic        length_ok;
    logic        chk_ok;
    logic        frame_we;
    logic        latch_en;
    logic        accepted;
    logic [15:0] rd_value;

    logic        rsp_valid_reg;
    logic [15:0] read_value_reg;
    logic        accepted_reg;

    assign pop       = q_valid && (!rsp_valid_reg || rsp.ready);
    assign byte_item = pop && !q_item.is_read;

    // a long enough silence forces the length byte
    assign cur_state = q_item.resync ? rcsfd_pkg::PS_LENGTH : state_reg;
    assign ptr_inc   = ptr_reg + 1'b1;
    assign length_ok = (q_item.data <= rcsfd_pkg::FrameMax)
                    && (q_item.data > rcsfd_pkg::FrameOverhead);
    assign chk_ok    = (csum_reg == {q_item.data, chk_lo_reg})
                    && (frame_reg[0] == rcsfd_pkg::CmdChannels);

    always_comb
    begin
        state_next = state_reg;
        if (byte_item)
        begin
            unique case (cur_state)
                rcsfd_pkg::PS_LENGTH:
                begin
                    state_next = length_ok ? rcsfd_pkg::PS_DATA : rcsfd_pkg::PS_DISCARD;
                end
                rcsfd_pkg::PS_DATA:
                begin
                    state_next = (ptr_inc == len_reg) ? rcsfd_pkg::PS_CHK_LO
                                                      : rcsfd_pkg::PS_DATA;
                end
                rcsfd_pkg::PS_CHK_LO:
                begin
                    state_next = rcsfd_pkg::PS_CHK_HI;
                end
                default:
                begin
                    state_next = rcsfd_pkg::PS_DISCARD;
                end
            endcase
        end
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        len_next    = len_reg;
        csum_next   = csum_reg;
        chk_lo_next = chk_lo_reg;
        frame_we    = 1'b0;
        latch_en    = 1'b0;
        accepted    = 1'b0;
        if (byte_item)
        begin
            unique case (cur_state)
                rcsfd_pkg::PS_LENGTH:
                begin
                    if (length_ok)
                    begin
                        ptr_next  = '0;
                        len_next  = rcsfd_pkg::FramePtrW'(q_item.data
                                                          - rcsfd_pkg::FrameOverhead);
                        csum_next = rcsfd_pkg::ChkInit - {8'h00, q_item.data};
                    end
                end
                rcsfd_pkg::PS_DATA:
                begin
                    frame_we  = 1'b1;
                    ptr_next  = ptr_inc;
                    csum_next = csum_reg - {8'h00, q_item.data};
                end
                rcsfd_pkg::PS_CHK_LO:
                begin
                    chk_lo_next = q_item.data;
                end
                rcsfd_pkg::PS_CHK_HI:
                begin
                    latch_en = chk_ok;
                    accepted = chk_ok;
                end
                default:
                begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        rd_value = '0;
        if (q_item.is_read && (q_item.data < 8'(rcsfd_pkg::NumChannels)))
        begin
            rd_value = chan_reg[q_item.data[rcsfd_pkg::ChIdxW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcsfd_pkg::PS_LENGTH;
            ptr_reg    <= '0;
            len_reg    <= '0;
            csum_reg   <= '0;
            chk_lo_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            len_reg    <= len_next;
            csum_reg   <= csum_next;
            chk_lo_reg <= chk_lo_next;
        end
    end

    // frame buffer and channel store read back zeros after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rcsfd_pkg::FrameDepth; i++)
            begin
                frame_reg[i] <= '0;
            end
            for (int k = 0; k < rcsfd_pkg::NumChannels; k++)
            begin
                chan_reg[k] <= '0;
            end
        end
        else
        begin
            if (frame_we)
            begin
                frame_reg[ptr_reg] <= q_item.data;
            end
            if (latch_en)
            begin
                for (int k = 0; k < rcsfd_pkg::NumChannels; k++)
                begin
                    chan_reg[k] <= {frame_reg[rcsfd_pkg::FramePtrW'(2 * k + 2)],
                                    frame_reg[rcsfd_pkg::FramePtrW'(2 * k + 1)]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            read_value_reg <= rd_value;
            accepted_reg   <= accepted;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.read_value     = read_value_reg;
    assign rsp.frame_accepted = accepted_reg;

    a_accept_has_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && accepted_reg) |-> (read_value_reg == '0))
        else $error("accepted frame carries a read value");

    a_pointer_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rcsfd_pkg::PS_DATA) |-> (ptr_reg < len_reg))
        else $error("byte pointer ran past payload length");

    a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp_valid_reg)
        else $error("popped item did not reach the output register");

endmodule

`default_nettype wire

@@ rtl/rc_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder
// Servo frame decoder top level: APB register, front, queue and back.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle as long as the output side keeps up.
// A byte item or channel read enters the front, which checks the silence
// against gap_ms, and waits in a two-entry queue; the back parses one item
// per cycle while the output register is free or being read, and its result
// is registered into the output register as the item is popped. The parser
// and channel latch in the back set this rate. Every item gives exactly one
// result: read_value for reads, frame_accepted for bytes.
// gap_ms sits at byte address 0 and should be written only while idle.
`default_nettype none

module rc_serial_frame_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rcsfd_req_if.sink                            req,
    rcsfd_rsp_if.source                          rsp,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rcsfd_pkg::ApbAddrW-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [7:0]        gap_ms_reg;
    logic [7:0]        gap_ms_next;
    logic              reg_sel;
    logic              q_full;
    logic              push;
    logic              pop;
    logic              q_valid;
    rcsfd_pkg::item_t  push_item;
    rcsfd_pkg::item_t  q_item;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rcsfd_pkg::RegGapMs);
    assign prdata  = reg_sel ? {24'h000000, gap_ms_reg} : 32'h0;

    always_comb
    begin
        gap_ms_next = gap_ms_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            gap_ms_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ms_reg <= rcsfd_pkg::GapMsReset;
        end
        else
        begin
            gap_ms_reg <= gap_ms_next;
        end
    end

    rcsfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .gap_ms    (gap_ms_reg),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    rcsfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    rcsfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
